>>> hdl/i2h_pkg.sv
package i2h_pkg;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [15:0] HALF_QNAN   = 16'h7E00;
  localparam logic [14:0] HALF_INF    = 15'h7C00;

  // Product of an 11-bit half significand and an 8-bit magnitude.
  typedef logic [18:0] prod_t;

  // Round sig * 2^(e-25) to half, nearest even. The product has at most 19 bits;
  // the exponent e is the biased half exponent (1 for subnormal scale).
  function automatic logic [14:0] round_prod(input prod_t sig, input logic [4:0] e);
    logic [4:0]  p;
    logic signed [7:0] pe;
    logic signed [7:0] q;
    logic [5:0]  sh;
    logic [18:0] r;
    logic [18:0] rem;
    logic [18:0] hw;
    logic [15:0] bits;
    p = 5'd0;
    for (int i = 0; i < 19; i++) begin
      if (sig[i]) p = 5'(i);
    end
    pe = 8'(signed'({3'b000, p})) + 8'(signed'({3'b000, e})) - 8'sd25;
    if (sig == '0) begin
      round_prod = 15'd0;
    end else if (pe > 8'sd15) begin
      round_prod = HALF_INF;
    end else begin
      q = (pe >= -8'sd14) ? (pe - 8'sd10) : -8'sd24;
      // shift = q - (e - 25), always >= 0 here since a normal scale gives sig >= 2^10 and a subnormal one gives e = 1
      sh = 6'(q - 8'(signed'({3'b000, e})) + 8'sd25);
      if (sh == 6'd0) begin
        r = sig;
      end else if (sh > 6'd19) begin
        r = '0;
      end else begin
        rem = sig & ((19'd1 << sh) - 19'd1);
        hw  = 19'd1 << (sh - 6'd1);
        r   = sig >> sh;
        if (rem > hw || (rem == hw && r[0])) r = r + 19'd1;
      end
      bits = 16'(({8'd0, q} + 16'd24) << 10) + 16'(r);
      round_prod = (bits >= 16'h7C00) ? HALF_INF : bits[14:0];
    end
  endfunction

  // Single to half, nearest even.
  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic        s;
    logic [7:0]  ex;
    logic [23:0] sig;
    logic [4:0]  p;
    logic signed [9:0] pe;
    logic signed [9:0] q;
    logic [9:0]  sh;
    logic [23:0] r;
    logic [23:0] rem;
    logic [23:0] hw;
    logic [15:0] bits;
    s   = f[31];
    ex  = f[30:23];
    sig = (ex == 8'd0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (sig[i]) p = 5'(i);
    end
    // unbiased exponent of sig lsb: ex-150, or -149 for subnormal
    pe = 10'(signed'({5'b0, p})) + ((ex == 8'd0) ? -10'sd149
         : 10'(signed'({2'b0, ex})) - 10'sd150);
    if (ex == 8'hFF) begin
      single_to_half = (f[22:0] != '0) ? HALF_QNAN : {s, HALF_INF};
    end else if (sig == '0) begin
      single_to_half = {s, 15'd0};
    end else if (pe > 10'sd15) begin
      single_to_half = {s, HALF_INF};
    end else begin
      q = (pe >= -10'sd14) ? (pe - 10'sd10) : -10'sd24;
      sh = 10'(q - ((ex == 8'd0) ? -10'sd149 : 10'(signed'({2'b0, ex})) - 10'sd150));
      if (sh > 10'd24) begin
        r = '0;
      end else if (sh == 10'd0) begin
        r = sig;
      end else begin
        rem = sig & ((24'd1 << sh) - 24'd1);
        hw  = 24'd1 << (sh - 10'd1);
        r   = sig >> sh;
        if (rem > hw || (rem == hw && r[0])) r = r + 24'd1;
      end
      // q + 24 lies in 0..29 here
      bits = {6'(q + 10'sd24), 10'd0} + 16'(r);
      single_to_half = {s, (bits >= 16'h7C00) ? HALF_INF : bits[14:0]};
    end
  endfunction

endpackage

>>> hdl/int8_to_half_dequantize_core.sv
// int8 to half-precision dequantizer.
// Requests enter on start with sample and last_in, taken when busy is low.
// busy is held low: one request is taken every clock.
// Each request gives one result on value_half and last_out, marked by
// done for exactly one cycle, after passing the input register, then the
// result register. Throughput is one per cycle.
// The scale is written over cfg_valid/cfg_ready with cfg_data, the IEEE
// single pattern; cfg_ready is always high. The scale is converted to half
// in a register stage of its own after the write; a request taken at any
// edge after the write edge uses the new scale. Write it only while
// no request is in flight.
// Reset (rst, synchronous) sets the scale to 1.0 and drops any request in
// flight. The receiver cannot stall; results must be taken when shown.
module int8_to_half_dequantize_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [7:0] sample,
  input  logic              last_in,
  output logic              done,
  output logic [15:0]       value_half,
  output logic              last_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  logic [31:0] scale_single;
  logic [15:0] scale_half;
  logic        in_valid;
  logic [7:0]  in_sample;
  logic        in_last;

  logic [7:0]  mag;
  logic        res_sign;
  logic [15:0] res_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_single <= i2h_pkg::SCALE_RESET;
      scale_half   <= i2h_pkg::single_to_half(i2h_pkg::SCALE_RESET);
      in_valid     <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_valid) scale_single <= cfg_data;
      scale_half <= i2h_pkg::single_to_half(scale_single);
      in_valid   <= start;
      done       <= in_valid;
    end
    in_sample  <= sample;
    in_last    <= last_in;
    value_half <= res_next;
    last_out   <= in_last;
  end

  always_comb begin
    mag      = in_sample[7] ? 8'(8'h00 - in_sample) : in_sample;
    res_sign = in_sample[7] ^ scale_half[15];
    if (scale_half[14:10] == 5'h1F) begin
      if (scale_half[9:0] != '0 || mag == 8'd0) res_next = i2h_pkg::HALF_QNAN;
      else res_next = {res_sign, i2h_pkg::HALF_INF};
    end else if (scale_half[14:10] == 5'd0) begin
      res_next = {res_sign, i2h_pkg::round_prod(
                   i2h_pkg::prod_t'({1'b0, scale_half[9:0]}) * i2h_pkg::prod_t'(mag),
                   5'd1)};
    end else begin
      res_next = {res_sign, i2h_pkg::round_prod(
                   i2h_pkg::prod_t'({1'b1, scale_half[9:0]}) * i2h_pkg::prod_t'(mag),
                   scale_half[14:10])};
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

class dequant_scoreboard;
  logic [31:0] scale_bits;
  logic [16:0] pending[$];
  int mismatches;

  function new();
    scale_bits = 32'h3F80_0000;
    mismatches = 0;
  endfunction

  // Round sign * sig * 2^e to half, nearest even.
  function logic [15:0] half_round(logic s, longint unsigned sig, int e);
    int p;
    int q;
    int sh;
    longint unsigned r;
    longint unsigned rem;
    longint unsigned hw;
    int unsigned bits;
    if (sig == 0) return {s, 15'd0};
    p = 0;
    while (p < 63 && (sig >> (p + 1)) != 0) p++;
    if (p + e > 15) return {s, 15'h7C00};
    q = (p + e >= -14) ? (p + e - 10) : -24;
    sh = q - e;
    if (sh <= 0) begin
      r = sig << (-sh);
    end else if (sh > 62) begin
      r = 0;
    end else begin
      rem = sig & ((64'd1 << sh) - 1);
      hw = 64'd1 << (sh - 1);
      r = sig >> sh;
      if (rem > hw || (rem == hw && r[0])) r++;
    end
    bits = 32'(longint'((q + 24) << 10) + r);
    if (bits >= 32'h7C00) bits = 32'h7C00;
    return {s, bits[14:0]};
  endfunction

  function logic [15:0] scale_as_half();
    logic [7:0] ex;
    ex = scale_bits[30:23];
    if (ex == 8'hFF)
      return (scale_bits[22:0] != 0) ? 16'h7E00 : {scale_bits[31], 15'h7C00};
    if (ex == 0) return half_round(scale_bits[31], 64'(scale_bits[22:0]), -149);
    return half_round(scale_bits[31], 64'({1'b1, scale_bits[22:0]}), int'(ex) - 150);
  endfunction

  function void note_request(logic signed [7:0] smp, logic lst);
    logic [15:0] h;
    logic [7:0] mag;
    logic sgn;
    logic [15:0] res;
    h = scale_as_half();
    mag = smp[7] ? -smp : smp;
    sgn = smp[7] ^ h[15];
    if (h[14:10] == 5'h1F)
      res = (h[9:0] != 0 || mag == 0) ? 16'h7E00 : {sgn, 15'h7C00};
    else if (h[14:10] == 0)
      res = half_round(sgn, 64'(h[9:0]) * 64'(mag), -24);
    else
      res = half_round(sgn, 64'({1'b1, h[9:0]}) * 64'(mag), int'(h[14:10]) - 25);
    pending.push_back({res, lst});
  endfunction

  function void check_result(logic [15:0] v, logic lst);
    logic [16:0] want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h last %b", v, lst);
      return;
    end
    want = pending.pop_front();
    if (want !== {v, lst}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h/%b got %h/%b", want[16:1], want[0], v, lst);
    end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [7:0] sample = 0;
  logic last_in = 0;
  logic done;
  logic [15:0] value_half;
  logic last_out;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = 0;
  int idle_pct;
  dequant_scoreboard board = new();

  int8_to_half_dequantize_core DUT (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) board.check_result(value_half, last_out);
  end

  // start stays high after a request; drop it only while idling
  task automatic send(logic signed [7:0] smp, logic lst);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    sample <= smp;
    last_in <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(smp, lst);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_scale(logic [31:0] val);
    drain();
    cfg_valid <= 1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.scale_bits = val;
    @(negedge clk);
    cfg_valid <= 0;
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [31:0] random_scale();
    case ($urandom_range(5, 0))
      0: return $urandom();
      1: return {1'($urandom_range(1, 0)), 8'($urandom_range(150, 100)), 23'($urandom())};
      2: return {1'($urandom_range(1, 0)), 8'($urandom_range(115, 100)), 23'($urandom())};
      default: return {1'($urandom_range(1, 0)), 8'($urandom_range(142, 112)),
                       23'($urandom())};
    endcase
  endfunction

  initial begin
    logic [31:0] edge_scales[12];
    idle_pct = 0;
    edge_scales = '{32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
                    32'hFFFF_FFFF, 32'h477F_F000, 32'h4780_0000, 32'h3380_0000,
                    32'h0000_0001, 32'h8000_0000, 32'hBF80_0000, 32'h387F_C000};
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (edge_scales[k]) begin
      write_scale(edge_scales[k]);
      send(8'sh80, 1'b1);
      send(8'sh7F, 1'b0);
      send(8'sh00, 1'b1);
      send(8'shFF, 1'b0);
    end
    write_scale(32'h3F80_0000);
    for (int n = 0; n < 750; n++) begin
      if (n == 0) idle_pct = 31;
      if (n == 250) idle_pct = 47;
      if (n == 500) idle_pct = 0;
      if (n % 50 == 49) write_scale(random_scale());
      if (n == 400) drain();
      send(8'($urandom()), 1'($urandom_range(1, 0)));
    end
    drain();
    repeat (8) @(negedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
